### hw/rtl/udcp_pkg.sv
// ============================================================================
// udcp_pkg
// Shared types and constants of the drive command parser: transfer payloads,
// framing modes, header bytes and the duty scaling constant.
// ============================================================================
package udcp_pkg;

    // Item kinds on the input channel
    localparam logic ACTION_BYTE = 1'b0;
    localparam logic ACTION_TICK = 1'b1;

    // Packet header and command bytes
    localparam logic [7:0] HDR_MOTOR_A = 8'hAA;
    localparam logic [7:0] HDR_MOTOR_B = 8'h55;
    localparam logic [7:0] HDR_GRIP_A  = 8'hAB;
    localparam logic [7:0] HDR_GRIP_B  = 8'hCD;
    localparam logic [7:0] GRIP_OPEN   = 8'h00;
    localparam logic [7:0] GRIP_CLOSE  = 8'h01;

    // Gripper request codes on the result
    localparam logic [1:0] REQ_NONE  = 2'd0;
    localparam logic [1:0] REQ_OPEN  = 2'd1;
    localparam logic [1:0] REQ_CLOSE = 2'd2;

    // Motor packet positions: payload bytes sit at counts 2..4, count 5 completes
    localparam logic [2:0] CNT_FIRST_HDR = 3'd1;
    localparam logic [2:0] CNT_PAY_FIRST = 3'd2;
    localparam logic [2:0] CNT_PAY_LAST  = 3'd4;
    localparam logic [2:0] CNT_IDLE      = 3'd0;

    // Speed clamp and duty = mag*255/100 as mag*1336965 >> 19
    localparam logic signed [15:0] SPEED_MAX     = 16'sd100;
    localparam logic signed [15:0] SPEED_MIN     = -16'sd100;
    localparam logic [6:0]         MAG_MAX       = 7'd100;
    localparam logic [27:0]        DUTY_RECIP    = 28'd1336965;
    localparam int                 DUTY_SHIFT    = 19;

    // Watchdog
    localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;
    localparam logic [15:0] LIMIT_RESET = 16'd500;

    // Register map (word index)
    localparam logic REG_LIMIT = 1'b0;

    typedef enum logic [2:0] {
        MODE_HUNT = 3'd0,
        MODE_M2   = 3'd1,
        MODE_MPAY = 3'd2,
        MODE_G2   = 3'd3,
        MODE_GCMD = 3'd4
    } frame_mode_t;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic       left_forward;
        logic       left_reverse;
        logic [7:0] left_duty;
        logic       right_forward;
        logic       right_reverse;
        logic [7:0] right_duty;
        logic [1:0] gripper_request;
        logic       gripper_hold;
        logic       drive_active;
        logic       watchdog_stop;
        logic       packet_done;
    } out_item_t;

    // Direction levels and duty of one motor
    typedef struct packed {
        logic       fwd;
        logic       rev;
        logic [7:0] duty;
    } motor_bits_t;

    typedef struct packed {
        motor_bits_t left;
        motor_bits_t right;
    } drive_t;

endpackage

### hw/rtl/uart_drive_command_parser_unit.sv
// ============================================================================
// uart_drive_command_parser_unit
// Drive command parser: turns UART bytes and millisecond ticks into motor
// direction/duty levels, gripper requests and a motor watchdog.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one item per transfer:
//   a received byte (action 0) or a one millisecond tick (action 1).
//   Output channel (out_valid/out_ready/out_data) returns exactly one result
//   per input item, in order: the current drive levels, gripper state and
//   the per-item pulses (gripper request, watchdog stop, packet done).
//   An item passes through the input register, then through the parser
//   logic into the result register. Throughput is one item per cycle while
//   the receiver takes results; the parser state updates as each item
//   advances, so consecutive items never wait on each other.
//   When the receiver stalls, the result register holds its item and the
//   input register holds the next one; in_ready drops only when both are
//   full. The APB port holds watchdog_limit_ms at address 0 (reset 500).
//   Reset clears the framing machine, stops the motors, releases the
//   gripper and zeroes the watchdog count; both channels come up empty.
// ============================================================================
module uart_drive_command_parser_unit
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_ready,
    input  udcp_pkg::in_item_t  in_data,

    output logic                out_valid,
    input  logic                out_ready,
    output udcp_pkg::out_item_t out_data,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic                in_valid_reg, in_valid_next;
    udcp_pkg::in_item_t  in_data_reg;
    logic                out_valid_reg, out_valid_next;
    udcp_pkg::out_item_t out_data_reg;
    logic [15:0]         limit_reg, limit_next;
    udcp_pkg::out_item_t result;
    logic                advance;
    logic                in_xfer;
    logic                cfg_write;

    // Handshake: advance when the result register is free or being drained
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign in_xfer   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign in_valid_next  = in_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    // Configuration register
    assign pready     = 1'b1;
    assign cfg_write  = psel && penable && pwrite && (paddr[2] == udcp_pkg::REG_LIMIT);
    assign limit_next = cfg_write ? pwdata[15:0] : limit_reg;
    assign prdata     = (paddr[2] == udcp_pkg::REG_LIMIT) ? {16'd0, limit_reg} : 32'd0;

    udcp_frame_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_data_reg),
        .limit   (limit_reg),
        .result  (result)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            limit_reg     <= udcp_pkg::LIMIT_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            limit_reg     <= limit_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_data_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    // Input side stalls only when both stages are full and the receiver waits
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (in_valid_reg && out_valid_reg && !out_ready))
        else $error("input stalled without a full pipeline");

    // A watchdog stop leaves the motors inactive and at zero duty
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.watchdog_stop) |->
        (!out_data.drive_active && out_data.left_duty == 8'd0
         && out_data.right_duty == 8'd0))
        else $error("watchdog stop with motors still driven");

    // A completed motor packet always activates the motors
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.packet_done) |-> out_data.drive_active)
        else $error("motor packet applied without active flag");

    // Direction levels never both high, and gripper hold follows the request
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
        (!(out_data.left_forward && out_data.left_reverse)
         && !(out_data.right_forward && out_data.right_reverse)
         && (out_data.gripper_request != udcp_pkg::REQ_CLOSE || out_data.gripper_hold)
         && (out_data.gripper_request != udcp_pkg::REQ_OPEN || !out_data.gripper_hold)))
        else $error("inconsistent direction or gripper levels");

endmodule

### hw/rtl/udcp_motor_map.sv
// ============================================================================
// udcp_motor_map
// Maps one little-endian signed 16-bit speed to direction levels and a PWM
// duty: clamp to +-100, duty = |v|*255/100.
// ============================================================================
module udcp_motor_map
(
    input  logic [7:0]           lo_byte,
    input  logic [7:0]           hi_byte,
    output udcp_pkg::motor_bits_t bits
);

    logic signed [15:0] speed;
    logic [15:0]        neg_speed;
    logic [6:0]         mag;
    logic [27:0]        prod;

    assign speed     = {hi_byte, lo_byte};
    assign neg_speed = 16'(-speed);

    // Clamp and take the magnitude
    always_comb
    begin
        if (speed > udcp_pkg::SPEED_MAX || speed < udcp_pkg::SPEED_MIN)
        begin
            mag = udcp_pkg::MAG_MAX;
        end
        else if (speed < 0)
        begin
            mag = neg_speed[6:0];
        end
        else
        begin
            mag = speed[6:0];
        end
    end

    // Scale to 0..255 through a reciprocal multiply
    assign prod = 28'(mag) * udcp_pkg::DUTY_RECIP;

    assign bits.fwd  = (speed > 0);
    assign bits.rev  = (speed < 0);
    assign bits.duty = prod[udcp_pkg::DUTY_SHIFT +: 8];

endmodule

### hw/rtl/udcp_frame_core.sv
// ============================================================================
// udcp_frame_core
// Framing machine, payload store, drive levels, gripper hold and watchdog.
// Computes the result of the registered item and updates state on advance.
// ============================================================================
module udcp_frame_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  udcp_pkg::in_item_t   item,
    input  logic [15:0]          limit,
    output udcp_pkg::out_item_t  result
);

    udcp_pkg::frame_mode_t mode_reg, mode_next;
    logic [2:0]            count_reg, count_next;
    logic [7:0]            pay_reg [3];
    udcp_pkg::drive_t      drive_reg, drive_next;
    logic                  active_reg, active_next;
    logic [16:0]           elapsed_reg, elapsed_next;
    logic                  hold_reg, hold_next;

    logic                  is_byte;
    logic                  store_en;
    logic                  complete;
    logic [1:0]            pay_idx;
    logic [16:0]           elapsed_inc;
    logic [1:0]            grip_req;
    logic                  wd_stop;
    udcp_pkg::motor_bits_t left_bits;
    udcp_pkg::motor_bits_t right_bits;

    assign is_byte  = (item.action == udcp_pkg::ACTION_BYTE);
    assign store_en = is_byte && (mode_reg == udcp_pkg::MODE_MPAY)
                      && (count_reg >= udcp_pkg::CNT_PAY_FIRST)
                      && (count_reg <= udcp_pkg::CNT_PAY_LAST);
    assign complete = is_byte && (mode_reg == udcp_pkg::MODE_MPAY) && !store_en;
    assign pay_idx  = 2'(count_reg - udcp_pkg::CNT_PAY_FIRST);

    // Speed mapping for the last payload byte together with the stored ones
    udcp_motor_map u_left_map
    (
        .lo_byte (pay_reg[0]),
        .hi_byte (pay_reg[1]),
        .bits    (left_bits)
    );

    udcp_motor_map u_right_map
    (
        .lo_byte (pay_reg[2]),
        .hi_byte (item.rx_byte),
        .bits    (right_bits)
    );

    // Next framing mode
    always_comb
    begin
        mode_next = mode_reg;
        if (is_byte)
        begin
            case (mode_reg)
                udcp_pkg::MODE_M2:
                begin
                    mode_next = (item.rx_byte == udcp_pkg::HDR_MOTOR_B) ?
                                udcp_pkg::MODE_MPAY : udcp_pkg::MODE_HUNT;
                end
                udcp_pkg::MODE_MPAY:
                begin
                    mode_next = store_en ? udcp_pkg::MODE_MPAY : udcp_pkg::MODE_HUNT;
                end
                udcp_pkg::MODE_G2:
                begin
                    mode_next = (item.rx_byte == udcp_pkg::HDR_GRIP_B) ?
                                udcp_pkg::MODE_GCMD : udcp_pkg::MODE_HUNT;
                end
                udcp_pkg::MODE_GCMD:
                begin
                    mode_next = udcp_pkg::MODE_HUNT;
                end
                default:
                begin
                    if (item.rx_byte == udcp_pkg::HDR_MOTOR_A)
                    begin
                        mode_next = udcp_pkg::MODE_M2;
                    end
                    else if (item.rx_byte == udcp_pkg::HDR_GRIP_A)
                    begin
                        mode_next = udcp_pkg::MODE_G2;
                    end
                    else
                    begin
                        mode_next = udcp_pkg::MODE_HUNT;
                    end
                end
            endcase
        end
    end

    // Saturating millisecond count
    assign elapsed_inc = (elapsed_reg == udcp_pkg::ELAPSED_MAX) ?
                         elapsed_reg : elapsed_reg + 17'd1;

    // Datapath and per-item outputs
    always_comb
    begin
        count_next   = count_reg;
        drive_next   = drive_reg;
        active_next  = active_reg;
        elapsed_next = elapsed_reg;
        hold_next    = hold_reg;
        grip_req     = udcp_pkg::REQ_NONE;
        wd_stop      = 1'b0;

        if (!is_byte)
        begin
            // Advance the watchdog and stop the motors on expiry
            elapsed_next = elapsed_inc;
            if (active_reg && (elapsed_inc > {1'b0, limit}))
            begin
                drive_next  = '0;
                active_next = 1'b0;
                wd_stop     = 1'b1;
            end
        end
        else
        begin
            case (mode_reg)
                udcp_pkg::MODE_M2:
                begin
                    count_next = (item.rx_byte == udcp_pkg::HDR_MOTOR_B) ?
                                 udcp_pkg::CNT_PAY_FIRST : udcp_pkg::CNT_IDLE;
                end
                udcp_pkg::MODE_MPAY:
                begin
                    if (store_en)
                    begin
                        count_next = count_reg + 3'd1;
                    end
                    else
                    begin
                        drive_next.left  = left_bits;
                        drive_next.right = right_bits;
                        elapsed_next     = '0;
                        active_next      = 1'b1;
                        count_next       = udcp_pkg::CNT_IDLE;
                    end
                end
                udcp_pkg::MODE_G2:
                begin
                    count_next = count_reg;
                end
                udcp_pkg::MODE_GCMD:
                begin
                    if (item.rx_byte == udcp_pkg::GRIP_OPEN)
                    begin
                        grip_req  = udcp_pkg::REQ_OPEN;
                        hold_next = 1'b0;
                    end
                    else if (item.rx_byte == udcp_pkg::GRIP_CLOSE)
                    begin
                        grip_req  = udcp_pkg::REQ_CLOSE;
                        hold_next = 1'b1;
                    end
                end
                default:
                begin
                    if (item.rx_byte == udcp_pkg::HDR_MOTOR_A)
                    begin
                        count_next = udcp_pkg::CNT_FIRST_HDR;
                    end
                end
            endcase
        end
    end

    // Result reflects the state after this item
    assign result.left_forward    = drive_next.left.fwd;
    assign result.left_reverse    = drive_next.left.rev;
    assign result.left_duty       = drive_next.left.duty;
    assign result.right_forward   = drive_next.right.fwd;
    assign result.right_reverse   = drive_next.right.rev;
    assign result.right_duty      = drive_next.right.duty;
    assign result.gripper_request = grip_req;
    assign result.gripper_hold    = hold_next;
    assign result.drive_active    = active_next;
    assign result.watchdog_stop   = wd_stop;
    assign result.packet_done     = complete;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= udcp_pkg::MODE_HUNT;
            count_reg   <= udcp_pkg::CNT_IDLE;
            drive_reg   <= '0;
            active_reg  <= 1'b0;
            elapsed_reg <= '0;
            hold_reg    <= 1'b0;
        end
        else if (advance)
        begin
            mode_reg    <= mode_next;
            count_reg   <= count_next;
            drive_reg   <= drive_next;
            active_reg  <= active_next;
            elapsed_reg <= elapsed_next;
            hold_reg    <= hold_next;
        end
    end

    // Payload bytes
    always_ff @(posedge clk)
    begin
        if (advance && store_en)
        begin
            pay_reg[pay_idx] <= item.rx_byte;
        end
    end

endmodule
